### rtl/hit_pair_distance_macros.svh
// Assertion macros shared by the hit pair distance RTL.
`ifndef HIT_PAIR_DISTANCE_MACROS_SVH
`define HIT_PAIR_DISTANCE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HPD_ASSERT_SAME(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HPD_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/hpd_pkg.sv
// Widths, constants, register codes and stage payload types for the hit pair distance block.
package hpd_pkg;

	localparam int SNR_W    = 20;
	localparam int DRIFT_W  = 24;
	localparam int TIME_W   = 42;
	localparam int DUR_W    = 24;
	localparam int FREQ_W   = 40;
	localparam int DIST_W   = 40;
	localparam int WEIGHT_W = 16;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] REG_FREQ_WEIGHT  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_WEIGHT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SNR_WEIGHT   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESH = 8'd3;

	localparam logic [WEIGHT_W-1:0] FREQ_WEIGHT_RST  = 16'd655;
	localparam logic [WEIGHT_W-1:0] DRIFT_WEIGHT_RST = 16'd2560;
	localparam logic [WEIGHT_W-1:0] SNR_WEIGHT_RST   = 16'd0;
	localparam logic [DIST_W-1:0]   MATCH_THRESH_RST = 40'd3276800;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// Datapath widths.
	localparam int MAG_W  = DRIFT_W;            // drift magnitude
	localparam int SUM_W  = TIME_W + 2;         // first + last, and dt
	localparam int DT_LO  = SUM_W / 2;
	localparam int DT_HI  = SUM_W - DT_LO;
	localparam int PP_W   = MAG_W + DT_HI;      // one partial product
	localparam int PAM_W  = MAG_W + SUM_W;      // drift * dt magnitude
	localparam int PA_W   = PAM_W + 1;
	localparam int FD_W   = FREQ_W + 1;
	localparam int FREQ_SH = 21;
	localparam int DIFF_W = PA_W + 2;
	localparam int ABS_W  = DIFF_W - 1;
	localparam int ABS_LO = ABS_W / 2;
	localparam int ABS_HI = ABS_W - ABS_LO;
	localparam int FP_W   = ABS_W + WEIGHT_W;
	localparam int TF_SH  = 25;
	localparam int TS_W   = WEIGHT_W + SNR_W;
	localparam int N_W    = DRIFT_W + 1;
	localparam int SQ_W   = 2 * MAG_W;          // sum of squared drifts
	localparam int Q_W    = 41;                 // normalized drift, Q.40 up to 1.0
	localparam int Q_LO   = 21;
	localparam int Q_HI   = Q_W - Q_LO;
	localparam int QQ_W   = 2 * Q_W - 1;
	localparam int QP_W   = 27;                 // slice of q^2 per weight product
	localparam int DP_W   = QQ_W + WEIGHT_W;
	localparam int TD_SH  = 40;

	// Pipeline timing.
	localparam int FRONT_LAT   = 3;
	localparam int FREQ_LAT    = 5;
	localparam int DIV_STAGES  = 1 + (Q_W - 1) / 2;
	localparam int DRIFT_LAT   = DIV_STAGES + 4;
	localparam int SNR_STAGE   = 2;
	localparam int TERM_STAGE  = FRONT_LAT + DRIFT_LAT;
	localparam int TF_DELAY    = DRIFT_LAT - FREQ_LAT;
	localparam int TS_DELAY    = TERM_STAGE - SNR_STAGE;
	localparam int TOTAL_LAT   = TERM_STAGE + 2;

	typedef struct packed {
		logic [PP_W-1:0] pal;
		logic [PP_W-1:0] pah;
		logic [PP_W-1:0] pbl;
		logic [PP_W-1:0] pbh;
		logic            neg_a;
		logic            neg_b;
		logic signed [FD_W-1:0] fd;
	} freq_in_t;

	typedef struct packed {
		logic [SQ_W-1:0] s;
		logic [N_W-1:0]  n;
	} drift_in_t;

endpackage

### rtl/hpd_delay.sv
// Enable-gated delay line that lines up one term with the slowest path.
module hpd_delay #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);
	logic [WIDTH-1:0] tap_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign dout = tap_q[DEPTH-1];
endmodule

### rtl/hpd_front.sv
// Front stages: drift magnitudes, midpoint offsets, partial products, drift power and the SNR term.
module hpd_front (
	input  logic                              clk,
	input  logic                              en,
	input  logic [hpd_pkg::SNR_W-1:0]         a_snr,
	input  logic signed [hpd_pkg::DRIFT_W-1:0] a_drift,
	input  logic [hpd_pkg::TIME_W-1:0]        a_start_time,
	input  logic [hpd_pkg::DUR_W-1:0]         a_duration,
	input  logic [hpd_pkg::FREQ_W-1:0]        a_start_freq,
	input  logic [hpd_pkg::SNR_W-1:0]         b_snr,
	input  logic signed [hpd_pkg::DRIFT_W-1:0] b_drift,
	input  logic [hpd_pkg::TIME_W-1:0]        b_start_time,
	input  logic [hpd_pkg::DUR_W-1:0]         b_duration,
	input  logic [hpd_pkg::FREQ_W-1:0]        b_start_freq,
	input  logic [hpd_pkg::WEIGHT_W-1:0]      snr_weight,
	output hpd_pkg::freq_in_t                 freq_in,
	output hpd_pkg::drift_in_t                drift_in,
	output logic [hpd_pkg::TS_W-1:0]          snr_term
);
	import hpd_pkg::*;

	logic [MAG_W-1:0]         ma_c, mb_c;
	logic signed [N_W-1:0]    dd_c;
	logic [N_W-1:0]           n_c;
	logic [TIME_W:0]          ea_c, eb_c, last_c;
	logic [TIME_W-1:0]        first_c;
	logic [SNR_W-1:0]         snrd_c;

	logic [MAG_W-1:0]  ma_s1, mb_s1;
	logic              na_s1, nb_s1;
	logic [SUM_W-1:0]  sum_s1;
	logic [TIME_W-1:0] ta_s1, tb_s1;
	logic [FREQ_W-1:0] fa_s1, fb_s1;
	logic [N_W-1:0]    n_s1;
	logic [SNR_W-1:0]  snrd_s1;

	logic [SUM_W-1:0]  twoa_c, twob_c;
	logic              nta_c, ntb_c;

	logic [SUM_W-1:0]       dta_s2, dtb_s2;
	logic                   sa_s2, sb_s2;
	logic [MAG_W-1:0]       ma_s2, mb_s2;
	logic signed [FD_W-1:0] fd_s2;
	logic [SQ_W-1:0]        sqa_s2, sqb_s2;
	logic [N_W-1:0]         n_s2;
	logic [TS_W-1:0]        ts_s2;

	logic [PP_W-1:0]        pal_s3, pah_s3, pbl_s3, pbh_s3;
	logic                   sa_s3, sb_s3;
	logic signed [FD_W-1:0] fd_s3;
	logic [SQ_W-1:0]        s_s3;
	logic [N_W-1:0]         n_s3;

	always_comb begin
		ma_c = a_drift[DRIFT_W-1] ? MAG_W'(-a_drift) : MAG_W'(a_drift);
		mb_c = b_drift[DRIFT_W-1] ? MAG_W'(-b_drift) : MAG_W'(b_drift);
		dd_c = N_W'(a_drift) - N_W'(b_drift);
		n_c = dd_c[N_W-1] ? N_W'(-dd_c) : N_W'(dd_c);
		ea_c = (TIME_W+1)'(a_start_time) + (TIME_W+1)'(a_duration);
		eb_c = (TIME_W+1)'(b_start_time) + (TIME_W+1)'(b_duration);
		last_c = (ea_c > eb_c) ? ea_c : eb_c;
		first_c = (a_start_time < b_start_time) ? a_start_time : b_start_time;
		snrd_c = (a_snr > b_snr) ? a_snr - b_snr : b_snr - a_snr;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1   <= ma_c;
			mb_s1   <= mb_c;
			na_s1   <= a_drift[DRIFT_W-1];
			nb_s1   <= b_drift[DRIFT_W-1];
			sum_s1  <= SUM_W'(first_c) + SUM_W'(last_c);
			ta_s1   <= a_start_time;
			tb_s1   <= b_start_time;
			fa_s1   <= a_start_freq;
			fb_s1   <= b_start_freq;
			n_s1    <= n_c;
			snrd_s1 <= snrd_c;
		end
	end

	// Offsets to the midpoint are (first + last) - 2 * start, kept as sign and magnitude.
	always_comb begin
		twoa_c = {1'b0, ta_s1, 1'b0};
		twob_c = {1'b0, tb_s1, 1'b0};
		nta_c = sum_s1 < twoa_c;
		ntb_c = sum_s1 < twob_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dta_s2 <= nta_c ? twoa_c - sum_s1 : sum_s1 - twoa_c;
			dtb_s2 <= ntb_c ? twob_c - sum_s1 : sum_s1 - twob_c;
			sa_s2  <= na_s1 ^ nta_c;
			sb_s2  <= nb_s1 ^ ntb_c;
			ma_s2  <= ma_s1;
			mb_s2  <= mb_s1;
			fd_s2  <= signed'(FD_W'(fa_s1) - FD_W'(fb_s1));
			sqa_s2 <= ma_s1 * ma_s1;
			sqb_s2 <= mb_s1 * mb_s1;
			n_s2   <= n_s1;
			ts_s2  <= snr_weight * snrd_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pal_s3 <= ma_s2 * dta_s2[DT_LO-1:0];
			pah_s3 <= ma_s2 * dta_s2[SUM_W-1:DT_LO];
			pbl_s3 <= mb_s2 * dtb_s2[DT_LO-1:0];
			pbh_s3 <= mb_s2 * dtb_s2[SUM_W-1:DT_LO];
			sa_s3  <= sa_s2;
			sb_s3  <= sb_s2;
			fd_s3  <= fd_s2;
			s_s3   <= sqa_s2 + sqb_s2;
			n_s3   <= n_s2;
		end
	end

	always_comb begin
		freq_in.pal   = pal_s3;
		freq_in.pah   = pah_s3;
		freq_in.pbl   = pbl_s3;
		freq_in.pbh   = pbh_s3;
		freq_in.neg_a = sa_s3;
		freq_in.neg_b = sb_s3;
		freq_in.fd    = fd_s3;
		drift_in.s    = s_s3;
		drift_in.n    = n_s3;
	end

	assign snr_term = ts_s2;
endmodule

### rtl/hpd_freq.sv
// Frequency term: projected frequency difference, absolute value, weight and saturation.
module hpd_freq (
	input  logic                          clk,
	input  logic                          en,
	input  hpd_pkg::freq_in_t             freq_in,
	input  logic [hpd_pkg::WEIGHT_W-1:0]  freq_weight,
	output logic [hpd_pkg::DIST_W-1:0]    freq_term
);
	import hpd_pkg::*;

	logic [PAM_W-1:0]         pam_a_c, pam_b_c;
	logic signed [PA_W-1:0]   pa_s4, pb_s4;
	logic signed [FD_W-1:0]   fd_s4;
	logic signed [DIFF_W-1:0] diff_s5;
	logic [ABS_W-1:0]         abs_s6;
	logic [ABS_LO+WEIGHT_W-1:0] plo_s7;
	logic [ABS_HI+WEIGHT_W-1:0] phi_s7;
	logic [FP_W-1:0]          prod_c;
	logic [FP_W-TF_SH-1:0]    shr_c;
	logic [DIST_W-1:0]        tf_s8;

	always_comb begin
		pam_a_c = (PAM_W'(freq_in.pah) << DT_LO) + PAM_W'(freq_in.pal);
		pam_b_c = (PAM_W'(freq_in.pbh) << DT_LO) + PAM_W'(freq_in.pbl);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s4 <= freq_in.neg_a ? signed'(PA_W'(0) - PA_W'(pam_a_c)) : signed'(PA_W'(pam_a_c));
			pb_s4 <= freq_in.neg_b ? signed'(PA_W'(0) - PA_W'(pam_b_c)) : signed'(PA_W'(pam_b_c));
			fd_s4 <= freq_in.fd;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s5 <= (DIFF_W'(fd_s4) <<< FREQ_SH) + DIFF_W'(pa_s4) - DIFF_W'(pb_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			abs_s6 <= diff_s5[DIFF_W-1] ? ABS_W'(-diff_s5) : ABS_W'(diff_s5);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s7 <= abs_s6[ABS_LO-1:0] * freq_weight;
			phi_s7 <= abs_s6[ABS_W-1:ABS_LO] * freq_weight;
		end
	end

	always_comb begin
		prod_c = (FP_W'(phi_s7) << ABS_LO) + FP_W'(plo_s7);
		shr_c = prod_c[FP_W-1:TF_SH];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tf_s8 <= (|shr_c[FP_W-TF_SH-1:DIST_W]) ? DIST_MAX : shr_c[DIST_W-1:0];
		end
	end

	assign freq_term = tf_s8;
endmodule

### rtl/hpd_drift.sv
// Drift term: pipelined restoring divider for |da-db|/(da^2+db^2), then square and weight.
module hpd_drift (
	input  logic                          clk,
	input  logic                          en,
	input  hpd_pkg::drift_in_t            drift_in,
	input  logic [hpd_pkg::WEIGHT_W-1:0]  drift_weight,
	output logic [hpd_pkg::DIST_W-1:0]    drift_term
);
	import hpd_pkg::*;

	logic [SQ_W-1:0] rem_s  [0:DIV_STAGES-1];
	logic [SQ_W-1:0] dsr_s  [0:DIV_STAGES-1];
	logic [Q_W-1:0]  quo_s  [0:DIV_STAGES-1];
	logic            zero_s [0:DIV_STAGES-1];

	logic            ge0_c;
	logic [Q_W-1:0]  q_c;
	logic [2*Q_LO-1:0]      pll_s25;
	logic [Q_HI+Q_LO-1:0]   plh_s25;
	logic [2*Q_HI-1:0]      phh_s25;
	logic [QQ_W-1:0]        sq_s26;
	logic [QP_W+WEIGHT_W-1:0] p0_s27, p1_s27, p2_s27;
	logic [DP_W-1:0]        dp_c;
	logic [DP_W-TD_SH-1:0]  shr_c;
	logic [DIST_W-1:0]      td_s28;

	// The quotient never exceeds 1.0, so the first stage settles the integer bit alone.
	assign ge0_c = SQ_W'(drift_in.n) >= drift_in.s;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= ge0_c ? SQ_W'(drift_in.n) - drift_in.s : SQ_W'(drift_in.n);
			dsr_s[0]  <= drift_in.s;
			quo_s[0]  <= Q_W'(ge0_c);
			zero_s[0] <= drift_in.s == '0;
		end
	end

	for (genvar k = 1; k < DIV_STAGES; k++) begin : g_div
		logic [SQ_W:0]   t1_c, t2_c;
		logic            g1_c, g2_c;
		logic [SQ_W-1:0] r1_c, r2_c;

		always_comb begin
			t1_c = {rem_s[k-1], 1'b0};
			g1_c = t1_c >= {1'b0, dsr_s[k-1]};
			r1_c = g1_c ? SQ_W'(t1_c - {1'b0, dsr_s[k-1]}) : SQ_W'(t1_c);
			t2_c = {r1_c, 1'b0};
			g2_c = t2_c >= {1'b0, dsr_s[k-1]};
			r2_c = g2_c ? SQ_W'(t2_c - {1'b0, dsr_s[k-1]}) : SQ_W'(t2_c);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= r2_c;
				dsr_s[k]  <= dsr_s[k-1];
				quo_s[k]  <= {quo_s[k-1][Q_W-3:0], g1_c, g2_c};
				zero_s[k] <= zero_s[k-1];
			end
		end
	end

	// Both drifts zero means no division at all and a zero term.
	assign q_c = zero_s[DIV_STAGES-1] ? '0 : quo_s[DIV_STAGES-1];

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s25 <= q_c[Q_LO-1:0] * q_c[Q_LO-1:0];
			plh_s25 <= q_c[Q_W-1:Q_LO] * q_c[Q_LO-1:0];
			phh_s25 <= q_c[Q_W-1:Q_LO] * q_c[Q_W-1:Q_LO];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s26 <= (QQ_W'(phh_s25) << (2 * Q_LO)) + (QQ_W'(plh_s25) << (Q_LO + 1))
				+ QQ_W'(pll_s25);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s27 <= sq_s26[QP_W-1:0] * drift_weight;
			p1_s27 <= sq_s26[2*QP_W-1:QP_W] * drift_weight;
			p2_s27 <= sq_s26[QQ_W-1:2*QP_W] * drift_weight;
		end
	end

	always_comb begin
		dp_c = (DP_W'(p2_s27) << (2 * QP_W)) + (DP_W'(p1_s27) << QP_W) + DP_W'(p0_s27);
		shr_c = dp_c[DP_W-1:TD_SH];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			td_s28 <= (|shr_c[DP_W-TD_SH-1:DIST_W]) ? DIST_MAX : shr_c[DIST_W-1:0];
		end
	end

	assign drift_term = td_s28;
endmodule

### rtl/hit_pair_distance.sv
// Hit pair distance top level: configuration registers, pipeline control and final sum.
// Usage:
// Input channel in_valid/in_stall takes one pair of hits per beat (a_* and b_* fields).
// Output channel out_valid/out_stall returns pair_distance and is_match for each pair,
// in the order the pairs were taken.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Indexes 0..3 select freq_weight, drift_weight, snr_weight and
// match_threshold; other indexes are ignored. Write only while the pipeline is empty.
// One pair is taken every cycle unless out_stall holds the pipeline. The latency from an
// accepted input beat to its output beat is set by the drift divider: one stage for the
// integer quotient bit, then 20 stages that resolve two fraction bits each.
// When out_stall is high with a result waiting, the whole pipeline holds, bubbles
// included, and in_stall rises in the same cycle; it falls again as soon as the held
// result is taken.
// Reset clears all valid bits and loads the register defaults.
`include "hit_pair_distance_macros.svh"

module hit_pair_distance (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [hpd_pkg::SNR_W-1:0]            a_snr,
	input  logic signed [hpd_pkg::DRIFT_W-1:0]   a_drift,
	input  logic [hpd_pkg::TIME_W-1:0]           a_start_time,
	input  logic [hpd_pkg::DUR_W-1:0]            a_duration,
	input  logic [hpd_pkg::FREQ_W-1:0]           a_start_freq,
	input  logic [hpd_pkg::SNR_W-1:0]            b_snr,
	input  logic signed [hpd_pkg::DRIFT_W-1:0]   b_drift,
	input  logic [hpd_pkg::TIME_W-1:0]           b_start_time,
	input  logic [hpd_pkg::DUR_W-1:0]            b_duration,
	input  logic [hpd_pkg::FREQ_W-1:0]           b_start_freq,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [hpd_pkg::DIST_W-1:0]           pair_distance,
	output logic                                 is_match,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [hpd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hpd_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import hpd_pkg::*;

	logic [WEIGHT_W-1:0] fw_q, dw_q, sw_q;
	logic [DIST_W-1:0]   thr_q;

	logic                 en;
	logic [TOTAL_LAT:1]   v_s;
	freq_in_t             freq_in;
	drift_in_t            drift_in;
	logic [TS_W-1:0]      ts_c, ts_d;
	logic [DIST_W-1:0]    tf_c, tf_d, td_c;
	logic [DIST_W:0]      sum1_c, sum2_c;
	logic [DIST_W-1:0]    sat1_c;
	logic [DIST_W-1:0]    total_s29;
	logic [DIST_W-1:0]    dist_s30;
	logic                 match_s30;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= FREQ_WEIGHT_RST;
			dw_q  <= DRIFT_WEIGHT_RST;
			sw_q  <= SNR_WEIGHT_RST;
			thr_q <= MATCH_THRESH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FREQ_WEIGHT:  fw_q  <= cfg_data[WEIGHT_W-1:0];
				REG_DRIFT_WEIGHT: dw_q  <= cfg_data[WEIGHT_W-1:0];
				REG_SNR_WEIGHT:   sw_q  <= cfg_data[WEIGHT_W-1:0];
				REG_MATCH_THRESH: thr_q <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline advances unless a finished result is being held at the output.
	assign en = !(v_s[TOTAL_LAT] && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[TOTAL_LAT-1:1], in_valid};
		end
	end

	hpd_front u_front (
		.clk          (clk),
		.en           (en),
		.a_snr        (a_snr),
		.a_drift      (a_drift),
		.a_start_time (a_start_time),
		.a_duration   (a_duration),
		.a_start_freq (a_start_freq),
		.b_snr        (b_snr),
		.b_drift      (b_drift),
		.b_start_time (b_start_time),
		.b_duration   (b_duration),
		.b_start_freq (b_start_freq),
		.snr_weight   (sw_q),
		.freq_in      (freq_in),
		.drift_in     (drift_in),
		.snr_term     (ts_c)
	);

	hpd_freq u_freq (
		.clk         (clk),
		.en          (en),
		.freq_in     (freq_in),
		.freq_weight (fw_q),
		.freq_term   (tf_c)
	);

	hpd_drift u_drift (
		.clk          (clk),
		.en           (en),
		.drift_in     (drift_in),
		.drift_weight (dw_q),
		.drift_term   (td_c)
	);

	hpd_delay #(.WIDTH(DIST_W), .DEPTH(TF_DELAY)) u_tf_dly (
		.clk  (clk),
		.en   (en),
		.din  (tf_c),
		.dout (tf_d)
	);

	hpd_delay #(.WIDTH(TS_W), .DEPTH(TS_DELAY)) u_ts_dly (
		.clk  (clk),
		.en   (en),
		.din  (ts_c),
		.dout (ts_d)
	);

	always_comb begin
		sum1_c = (DIST_W+1)'(tf_d) + (DIST_W+1)'(td_c);
		sat1_c = sum1_c[DIST_W] ? DIST_MAX : sum1_c[DIST_W-1:0];
		sum2_c = (DIST_W+1)'(sat1_c) + (DIST_W+1)'(ts_d);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			total_s29 <= sum2_c[DIST_W] ? DIST_MAX : sum2_c[DIST_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s30  <= total_s29;
			match_s30 <= total_s29 < thr_q;
		end
	end

	assign out_valid     = v_s[TOTAL_LAT];
	assign pair_distance = dist_s30;
	assign is_match      = match_s30;

	`HPD_ASSERT_SAME(a_hold_backpressure, clk, arst_n, out_valid && out_stall, in_stall, "input taken while output is held")
	`HPD_ASSERT_SAME(a_match_flag, clk, arst_n, out_valid, is_match == (pair_distance < thr_q), "match flag disagrees with distance")
	`HPD_ASSERT_NEXT(a_last_stage_moves, clk, arst_n, v_s[TOTAL_LAT-1] && en, out_valid, "beat lost before output register")
endmodule

### tb/hpd_checker.sv
// Checker for the hit pair distance block: mirrors the registers, predicts and compares results.
module hpd_checker
	import hpd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic [SNR_W-1:0]          a_snr,
	input  logic signed [DRIFT_W-1:0] a_drift,
	input  logic [TIME_W-1:0]         a_start_time,
	input  logic [DUR_W-1:0]          a_duration,
	input  logic [FREQ_W-1:0]         a_start_freq,
	input  logic [SNR_W-1:0]          b_snr,
	input  logic signed [DRIFT_W-1:0] b_drift,
	input  logic [TIME_W-1:0]         b_start_time,
	input  logic [DUR_W-1:0]          b_duration,
	input  logic [FREQ_W-1:0]         b_start_freq,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [DIST_W-1:0]         pair_distance,
	input  logic                      is_match,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output int                        fail_count,
	output int                        pending,
	output int                        result_count,
	output int                        match_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic              match;
	} dist_exp_t;

	dist_exp_t                dist_q[$];
	logic [WEIGHT_W-1:0]      w_freq, w_drift, w_snr;
	logic [DIST_W-1:0]        thresh;

	// Product of a magnitude and a weight, shifted down and clipped to the distance range.
	function automatic logic [DIST_W-1:0] clip_scaled(input logic [127:0] v,
		input logic [WEIGHT_W-1:0] w, input int sh);
		logic [191:0] p;
		p = v * w;
		p = p >> sh;
		return (p > DIST_MAX) ? DIST_MAX : p[DIST_W-1:0];
	endfunction

	function automatic logic [DIST_W-1:0] pair_dist(
		input logic [SNR_W-1:0] sa, input logic signed [DRIFT_W-1:0] ra,
		input logic [TIME_W-1:0] ta, input logic [DUR_W-1:0] la, input logic [FREQ_W-1:0] fa,
		input logic [SNR_W-1:0] sb, input logic signed [DRIFT_W-1:0] rb,
		input logic [TIME_W-1:0] tb, input logic [DUR_W-1:0] lb, input logic [FREQ_W-1:0] fb);
		logic [43:0]          first, last, ea, eb, span_sum;
		logic signed [47:0]   dta, dtb;
		logic signed [127:0]  ra_w, rb_w, dta_w, dtb_w, fdiff;
		logic [127:0]         fabs, q;
		logic [23:0]          ma, mb;
		logic [47:0]          s;
		logic signed [25:0]   dd;
		logic [24:0]          n;
		logic [SNR_W-1:0]     sd;
		logic [35:0]          ts;
		logic [DIST_W-1:0]    tf, td;
		logic [DIST_W+1:0]    total;
		first = (ta < tb) ? ta : tb;
		ea = ta + la;
		eb = tb + lb;
		last = (ea > eb) ? ea : eb;
		span_sum = first + last;
		// Offsets to the span midpoint, one extra fraction bit.
		dta = $signed({4'b0, span_sum}) - $signed({5'b0, ta, 1'b0});
		dtb = $signed({4'b0, span_sum}) - $signed({5'b0, tb, 1'b0});
		ra_w = ra;
		rb_w = rb;
		dta_w = dta;
		dtb_w = dtb;
		fdiff = $signed({67'b0, fa, 21'b0}) - $signed({67'b0, fb, 21'b0})
			+ ra_w * dta_w - rb_w * dtb_w;
		fabs = (fdiff < 0) ? -fdiff : fdiff;
		tf = clip_scaled(fabs, w_freq, TF_SH);

		ma = ra[DRIFT_W-1] ? -ra : ra;
		mb = rb[DRIFT_W-1] ? -rb : rb;
		s = {24'b0, ma} * ma + {24'b0, mb} * mb;
		dd = ra - rb;
		n = (dd < 0) ? -dd : dd;
		q = (s != 0) ? (({103'b0, n} << 40) / s) : 128'd0;
		td = clip_scaled(q * q, w_drift, TD_SH);

		sd = (sa > sb) ? sa - sb : sb - sa;
		ts = sd * w_snr;

		total = tf + td;
		if (total > DIST_MAX) total = DIST_MAX;
		total = total + ts;
		if (total > DIST_MAX) total = DIST_MAX;
		return total[DIST_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dist_exp_t e;
		if (!arst_n) begin
			w_freq <= FREQ_WEIGHT_RST;
			w_drift <= DRIFT_WEIGHT_RST;
			w_snr <= SNR_WEIGHT_RST;
			thresh <= MATCH_THRESH_RST;
			dist_q.delete();
			fail_count = 0;
			pending = 0;
			result_count = 0;
			match_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FREQ_WEIGHT: w_freq <= cfg_data[WEIGHT_W-1:0];
					REG_DRIFT_WEIGHT: w_drift <= cfg_data[WEIGHT_W-1:0];
					REG_SNR_WEIGHT: w_snr <= cfg_data[WEIGHT_W-1:0];
					REG_MATCH_THRESH: thresh <= cfg_data[DIST_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				e.distance = pair_dist(a_snr, a_drift, a_start_time, a_duration, a_start_freq,
					b_snr, b_drift, b_start_time, b_duration, b_start_freq);
				e.match = (e.distance < thresh);
				dist_q.insert(dist_q.size(), e);
			end
			if (out_valid && !out_stall) begin
				result_count++;
				if (is_match) match_count++;
				if (dist_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result beat with nothing expected: dist=%h match=%b",
							$realtime, pair_distance, is_match);
				end else begin
					e = dist_q.pop_front();
					if (pair_distance !== e.distance || is_match !== e.match) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch dist exp=%h act=%h match exp=%b act=%b",
								$realtime, e.distance, pair_distance, e.match, is_match);
					end
				end
			end
			pending = dist_q.size();
		end
	end

endmodule

### tb/tb_top.sv
// Top of the hit pair distance testbench: clock, reset, stimulus and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hpd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;
	localparam int PHASE_ITEMS = 340;

	typedef struct {
		logic [SNR_W-1:0]   a_snr, b_snr;
		logic [DRIFT_W-1:0] a_drift, b_drift;
		logic [TIME_W-1:0]  a_t, b_t;
		logic [DUR_W-1:0]   a_d, b_d;
		logic [FREQ_W-1:0]  a_f, b_f;
	} hit_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_stall;
	logic [SNR_W-1:0] a_snr = '0, b_snr = '0;
	logic signed [DRIFT_W-1:0] a_drift = '0, b_drift = '0;
	logic [TIME_W-1:0] a_start_time = '0, b_start_time = '0;
	logic [DUR_W-1:0] a_duration = '0, b_duration = '0;
	logic [FREQ_W-1:0] a_start_freq = '0, b_start_freq = '0;
	logic out_valid, out_stall = 1'b0;
	logic [DIST_W-1:0] pair_distance;
	logic is_match;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int fail_count, pending, result_count, match_count;
	int tx_pct = 0, rx_pct = 0;
	logic hold_req = 1'b0, hold_seen = 1'b0;
	int hold_left = 0;
	int sent = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	hit_pair_distance u_top (.*);

	hpd_checker u_chk (.*);

	// Receiver side: random stalls, plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_req && !hold_seen) begin
			hold_seen <= 1'b1;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_pct);
		end
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic hit_pair_t random_pair();
		hit_pair_t p;
		int kind;
		kind = $urandom_range(9);
		p.a_snr = SNR_W'($urandom); p.b_snr = SNR_W'($urandom);
		p.a_drift = DRIFT_W'($urandom); p.b_drift = DRIFT_W'($urandom);
		p.a_t = TIME_W'(rnd64()); p.b_t = TIME_W'(rnd64());
		p.a_d = DUR_W'($urandom); p.b_d = DUR_W'($urandom);
		p.a_f = FREQ_W'(rnd64()); p.b_f = FREQ_W'(rnd64());
		if (kind <= 4) begin
			// Two hits of nearly the same signal, so matches show up.
			p.a_drift = DRIFT_W'(int'($urandom_range(2000)) - 1000);
			p.b_drift = p.a_drift + DRIFT_W'(int'($urandom_range(40)) - 20);
			p.a_t = TIME_W'($urandom_range(1 << 20));
			p.b_t = p.a_t + TIME_W'($urandom_range(512));
			p.a_d = DUR_W'($urandom_range(1 << 14));
			p.b_d = p.a_d + DUR_W'($urandom_range(256));
			p.b_f = p.a_f + FREQ_W'(int'($urandom_range(4000)) - 2000);
			p.b_snr = p.a_snr + SNR_W'(int'($urandom_range(64)) - 32);
		end else if (kind == 8) begin
			p.a_drift = '0;
			p.b_drift = '0;
		end else if (kind == 9) begin
			p.a_snr = $urandom_range(1) ? '1 : '0;
			p.b_snr = $urandom_range(1) ? '1 : '0;
			p.a_drift = $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
			p.b_drift = $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
			p.a_t = $urandom_range(1) ? '1 : '0;
			p.b_t = $urandom_range(1) ? '1 : '0;
			p.a_d = $urandom_range(1) ? '1 : '0;
			p.b_d = $urandom_range(1) ? '1 : '0;
			p.a_f = $urandom_range(1) ? '1 : '0;
			p.b_f = $urandom_range(1) ? '1 : '0;
		end
		return p;
	endfunction

	task automatic send_pair(input hit_pair_t p);
		while ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		a_snr <= p.a_snr; a_drift <= p.a_drift; a_start_time <= p.a_t;
		a_duration <= p.a_d; a_start_freq <= p.a_f;
		b_snr <= p.b_snr; b_drift <= p.b_drift; b_start_time <= p.b_t;
		b_duration <= p.b_d; b_start_freq <= p.b_f;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	// Each write drops cfg_valid again before the task returns.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Weights carry random junk above bit 15, which the block must ignore.
	task automatic set_weights(input logic [15:0] fw, input logic [15:0] dw,
		input logic [15:0] sw, input logic [39:0] th);
		write_reg(REG_FREQ_WEIGHT, CFG_DATA_W'({$urandom, fw}));
		write_reg(REG_DRIFT_WEIGHT, CFG_DATA_W'({$urandom, dw}));
		write_reg(REG_SNR_WEIGHT, CFG_DATA_W'({$urandom, sw}));
		write_reg(REG_MATCH_THRESH, th);
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin
		hit_pair_t p;
		logic [39:0] th;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset weights.
		p = '{default: '0};
		send_pair(p);
		p = '{a_snr: '1, b_snr: '1, a_drift: 24'h7FFFFF, b_drift: 24'h7FFFFF, a_t: '1, b_t: '1,
			a_d: '1, b_d: '1, a_f: '1, b_f: '1};
		send_pair(p);
		p.a_drift = 24'h800000; p.b_drift = 24'h800000;
		send_pair(p);
		p.b_drift = 24'h7FFFFF; p.a_f = '0; p.b_t = '0;
		send_pair(p);
		p = '{default: '0};
		p.a_drift = 24'd1; p.b_drift = -24'sd1; p.a_d = 24'd100;
		send_pair(p);
		p.a_drift = 24'd1; p.b_drift = '0;
		send_pair(p);
		p = random_pair();
		p.a_drift = '0; p.b_drift = '0;
		send_pair(p);
		p.b_snr = p.a_snr; p.b_drift = p.a_drift; p.b_t = p.a_t; p.b_d = p.a_d; p.b_f = p.a_f;
		send_pair(p);
		p.b_t = p.a_t + TIME_W'(1000); p.b_f = p.a_f + FREQ_W'(5);
		send_pair(p);
		drain();

		// SNR term alone: a distance equal to the threshold is no match, one below it is.
		set_weights(16'd0, 16'd0, 16'd1, 40'd1000);
		write_reg(REG_UNUSED, '1);
		p = random_pair();
		p.a_snr = 20'd1000; p.b_snr = 20'd0;
		send_pair(p);
		p.a_snr = 20'd0; p.b_snr = 20'd999;
		send_pair(p);
		p.b_snr = 20'd1001;
		send_pair(p);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_weights(16'd655, 16'd2560, 16'd256, 40'd3276800);
				1: set_weights('1, '1, '1, '1);
				2: set_weights('0, '0, '0, '0);
				3: set_weights(16'd1, 16'd1, 16'd1, DIST_W'(rnd64()));
				default: begin
					th = DIST_W'(rnd64() >> $urandom_range(39));
					set_weights(WEIGHT_W'($urandom), WEIGHT_W'($urandom),
						WEIGHT_W'($urandom), th);
				end
			endcase
			case (ph % 3)
				0: begin tx_pct = 21; rx_pct = 52; end
				1: begin tx_pct = 52; rx_pct = 21; end
				default: begin tx_pct = 0; rx_pct = 0; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 0 && i == 50) hold_req = 1'b1;
				if (ph == 1 && i == 100) begin
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				send_pair(random_pair());
			end
			drain();
		end

		$display("Sent %0d hit pairs over seven register settings; %0d results checked, %0d matches.",
			sent, result_count, match_count);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
